@@ design/signed_integer_to_custom_radix_text_unit_defines.svh @@
// Assertion macros used by the design file
`ifndef SIGNED_INTEGER_TO_CUSTOM_RADIX_TEXT_UNIT_DEFINES_SVH
`define SIGNED_INTEGER_TO_CUSTOM_RADIX_TEXT_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define SITCRT_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Consequent must hold in the cycle after the antecedent
`define SITCRT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

@@ design/sitcrt_pkg.sv @@
package sitcrt_pkg;

   // Defaults for the top-level parameters
   localparam int ALPHABET_DEPTH_DEF = 256;
   localparam int DIGIT_SLOTS_DEF    = 32;
   localparam int VALUE_BITS_DEF     = 32;

   localparam logic [7:0] SYM_PLUS  = 8'h2B;
   localparam logic [7:0] SYM_MINUS = 8'h2D;

   // Request modes
   localparam logic [1:0] MODE_CLEAR   = 2'd0;
   localparam logic [1:0] MODE_APPEND  = 2'd1;
   localparam logic [1:0] MODE_CONVERT = 2'd2;

   // Conversion sequencer
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV,
      ST_LOOKUP,
      ST_STORE,
      ST_SIGN,
      ST_READ,
      ST_EMIT,
      ST_ERR,
      ST_SCAN_RD,
      ST_SCAN_CMP
   } state_type;

endpackage

@@ design/signed_integer_to_custom_radix_text_unit.sv @@
// An append beat scans the stored symbols for a repeat, skipped when the alphabet is
// already bad, the symbol is a sign or nothing is stored yet.
// A convert beat runs a bit-serial restoring divider for each digit, then emits the sign
// (for a negative value) and the digits.
// One beat at a time: req_ready is low until the scan or the last character is registered.
// Reset (synchronous) empties the alphabet and idles the sequencer; memories keep contents.
`include "signed_integer_to_custom_radix_text_unit_defines.svh"

module signed_integer_to_custom_radix_text_unit #(
   parameter int ALPHABET_DEPTH = sitcrt_pkg::ALPHABET_DEPTH_DEF,
   parameter int DIGIT_SLOTS    = sitcrt_pkg::DIGIT_SLOTS_DEF,
   parameter int VALUE_BITS     = sitcrt_pkg::VALUE_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [1:0]                   req_mode,
   input  logic [7:0]                   req_symbol,
   input  logic signed [VALUE_BITS-1:0] req_value,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [7:0]                   rsp_character,
   output logic                         rsp_last,
   output logic                         rsp_invalid_base
);

   localparam int CW = $clog2(ALPHABET_DEPTH + 1);
   localparam int AW = $clog2(ALPHABET_DEPTH);
   localparam int NW = $clog2(DIGIT_SLOTS + 1);
   localparam int DW = $clog2(DIGIT_SLOTS);
   localparam int BW = $clog2(VALUE_BITS);

   // Control state
   sitcrt_pkg::state_type state_ff, state_in;
   logic [CW-1:0]                  count_ff, count_in;
   logic                           bad_ff, bad_in;
   logic                           rsp_valid_ff, rsp_valid_in;

   // Datapath state
   logic [VALUE_BITS-1:0] mag_ff, mag_in;
   logic [CW-1:0]         rem_ff, rem_in;
   logic [BW-1:0]         bit_ff, bit_in;
   logic [NW-1:0]         n_ff, n_in;
   logic                  neg_ff, neg_in;
   logic [7:0]            sym_ff, sym_in;
   logic [7:0]            rsp_char_ff, rsp_char_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  rsp_bad_ff, rsp_bad_in;

   // Memories
   logic [7:0] alpha_mem [ALPHABET_DEPTH];
   logic [7:0] dbuf_mem  [DIGIT_SLOTS];
   logic [7:0] alpha_rd_ff;
   logic [7:0] dbuf_rd_ff;
   logic       alpha_we;
   logic       dbuf_we;

   logic              accept;
   logic              rsp_free;
   logic [CW:0]       trial;
   logic [CW:0]       base_ext;
   logic [CW:0]       diff;
   logic              geq;
   logic [NW-1:0]     n_inc;
   logic [NW-1:0]     n_dec;
   logic [DW-1:0]     dbuf_rd_idx;
   logic [CW-1:0]     rem_inc;
   logic [CW-1:0]     count_dec;
   logic              sign_sym;

   assign accept      = req_valid && req_ready;
   assign req_ready   = (state_ff == sitcrt_pkg::ST_IDLE);
   assign rsp_free    = !rsp_valid_ff || rsp_ready;

   // One restoring division step
   assign trial       = {rem_ff, mag_ff[VALUE_BITS-1]};
   assign base_ext    = {1'b0, count_ff};
   assign diff        = trial - base_ext;
   assign geq         = (trial >= base_ext);
   assign n_inc       = n_ff + NW'(1);
   assign n_dec       = n_ff - NW'(1);
   assign dbuf_rd_idx = n_dec[DW-1:0];

   // Repeat scan: rem_ff doubles as the index of the stored symbol being checked
   assign rem_inc     = rem_ff + CW'(1);
   assign count_dec   = count_ff - CW'(1);
   assign sign_sym    = (req_symbol == sitcrt_pkg::SYM_PLUS) ||
                        (req_symbol == sitcrt_pkg::SYM_MINUS);

   // Hold state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sitcrt_pkg::ST_IDLE;
         count_ff     <= '0;
         bad_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         bad_ff       <= bad_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      rem_ff      <= rem_in;
      bit_ff      <= bit_in;
      n_ff        <= n_in;
      neg_ff      <= neg_in;
      sym_ff      <= sym_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
      rsp_bad_ff  <= rsp_bad_in;
   end

   // Alphabet store: write on append, registered read at the remainder
   always_ff @(posedge clock) begin
      if (alpha_we) begin
         alpha_mem[count_ff[AW-1:0]] <= req_symbol;
      end
      alpha_rd_ff <= alpha_mem[rem_ff[AW-1:0]];
   end

   // Digit buffer: least significant digit first, read back from the top
   always_ff @(posedge clock) begin
      if (dbuf_we) begin
         dbuf_mem[n_ff[DW-1:0]] <= alpha_rd_ff;
      end
      dbuf_rd_ff <= dbuf_mem[dbuf_rd_idx];
   end

   // Sequencer and next values
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      bad_in       = bad_ff;
      mag_in       = mag_ff;
      rem_in       = rem_ff;
      bit_in       = bit_ff;
      n_in         = n_ff;
      neg_in       = neg_ff;
      sym_in       = sym_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_bad_in   = rsp_bad_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      alpha_we     = 1'b0;
      dbuf_we      = 1'b0;

      unique case (state_ff)
         sitcrt_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_mode)
                  sitcrt_pkg::MODE_CLEAR: begin
                     count_in = '0;
                     bad_in   = 1'b0;
                  end
                  sitcrt_pkg::MODE_APPEND: begin
                     if (count_ff == CW'(ALPHABET_DEPTH)) begin
                        bad_in = 1'b1;
                     end else begin
                        if (sign_sym) begin
                           bad_in = 1'b1;
                        end
                        alpha_we = 1'b1;
                        count_in = count_ff + CW'(1);
                        sym_in   = req_symbol;
                        rem_in   = '0;
                        // look for a repeat only while the alphabet is still good
                        if (!bad_ff && !sign_sym && count_ff != '0) begin
                           state_in = sitcrt_pkg::ST_SCAN_RD;
                        end
                     end
                  end
                  sitcrt_pkg::MODE_CONVERT: begin
                     if (count_ff < CW'(2) || bad_ff) begin
                        state_in = sitcrt_pkg::ST_ERR;
                     end else begin
                        neg_in   = req_value[VALUE_BITS-1];
                        mag_in   = req_value[VALUE_BITS-1] ? (~req_value + VALUE_BITS'(1))
                                                           : req_value;
                        rem_in   = '0;
                        bit_in   = '0;
                        n_in     = '0;
                        state_in = sitcrt_pkg::ST_DIV;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         sitcrt_pkg::ST_SCAN_RD: begin
            // stored symbol read is registered this cycle
            state_in = sitcrt_pkg::ST_SCAN_CMP;
         end
         sitcrt_pkg::ST_SCAN_CMP: begin
            rem_in = rem_inc;
            if (alpha_rd_ff == sym_ff) begin
               bad_in   = 1'b1;
               state_in = sitcrt_pkg::ST_IDLE;
            end else if (rem_inc == count_dec) begin
               state_in = sitcrt_pkg::ST_IDLE;
            end else begin
               state_in = sitcrt_pkg::ST_SCAN_RD;
            end
         end
         sitcrt_pkg::ST_DIV: begin
            rem_in = geq ? diff[CW-1:0] : trial[CW-1:0];
            mag_in = {mag_ff[VALUE_BITS-2:0], geq};
            bit_in = bit_ff + BW'(1);
            if (bit_ff == BW'(VALUE_BITS - 1)) begin
               state_in = sitcrt_pkg::ST_LOOKUP;
            end
         end
         sitcrt_pkg::ST_LOOKUP: begin
            // symbol read is registered this cycle
            state_in = sitcrt_pkg::ST_STORE;
         end
         sitcrt_pkg::ST_STORE: begin
            dbuf_we = 1'b1;
            n_in    = n_inc;
            rem_in  = '0;
            bit_in  = '0;
            if (mag_ff == '0 || n_inc == NW'(DIGIT_SLOTS)) begin
               state_in = sitcrt_pkg::ST_SIGN;
            end else begin
               state_in = sitcrt_pkg::ST_DIV;
            end
         end
         sitcrt_pkg::ST_SIGN: begin
            if (!neg_ff) begin
               state_in = sitcrt_pkg::ST_READ;
            end else if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = sitcrt_pkg::SYM_MINUS;
               rsp_last_in  = 1'b0;
               rsp_bad_in   = 1'b0;
               state_in     = sitcrt_pkg::ST_READ;
            end
         end
         sitcrt_pkg::ST_READ: begin
            // digit read is registered this cycle
            state_in = sitcrt_pkg::ST_EMIT;
         end
         sitcrt_pkg::ST_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = dbuf_rd_ff;
               rsp_last_in  = (n_ff == NW'(1));
               rsp_bad_in   = 1'b0;
               n_in         = n_dec;
               state_in     = (n_ff == NW'(1)) ? sitcrt_pkg::ST_IDLE : sitcrt_pkg::ST_READ;
            end
         end
         sitcrt_pkg::ST_ERR: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = '0;
               rsp_last_in  = 1'b1;
               rsp_bad_in   = 1'b1;
               state_in     = sitcrt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sitcrt_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_character    = rsp_char_ff;
   assign rsp_last         = rsp_last_ff;
   assign rsp_invalid_base = rsp_bad_ff;

   // Checks
   `SITCRT_ASSERT_SAME(a_err_beat_is_last, clock, reset,
      rsp_valid_ff && rsp_bad_ff, rsp_last_ff && rsp_char_ff == 8'h00)
   `SITCRT_ASSERT_SAME(a_count_in_range, clock, reset,
      1'b1, count_ff <= CW'(ALPHABET_DEPTH))
   `SITCRT_ASSERT_SAME(a_rem_below_base, clock, reset,
      state_ff == sitcrt_pkg::ST_DIV, rem_ff < count_ff)
   `SITCRT_ASSERT_NEXT(a_convert_leaves_idle, clock, reset,
      accept && req_mode == sitcrt_pkg::MODE_CONVERT, state_ff != sitcrt_pkg::ST_IDLE)

endmodule

@@ test/tb_signed_integer_to_custom_radix_text_unit.sv @@
module tb_signed_integer_to_custom_radix_text_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int         ALPHABET_SIZE  = sitcrt_pkg::ALPHABET_DEPTH_DEF;
   localparam logic [1:0] MODE_CLEAR     = sitcrt_pkg::MODE_CLEAR;
   localparam logic [1:0] MODE_APPEND    = sitcrt_pkg::MODE_APPEND;
   localparam logic [1:0] MODE_CONVERT   = sitcrt_pkg::MODE_CONVERT;
   localparam logic [1:0] MODE_UNUSED    = 2'd3;
   localparam logic [7:0] SYM_PLUS       = sitcrt_pkg::SYM_PLUS;
   localparam logic [7:0] SYM_MINUS      = sitcrt_pkg::SYM_MINUS;
   localparam int         RANDOM_ITEMS   = 80;
   localparam int         PHASES         = 5;
   localparam int         PRESSURE_PHASE = 4;
   localparam int         HOLD_CYCLES    = 3000;
   localparam int         STALL_LIMIT    = 20000;
   localparam int         DRAIN_CYCLES   = 40;
   localparam int         DIRECTED_ROWS  = 25;

   typedef struct packed {
      logic [7:0] character;
      logic       last;
      logic       invalid_base;
   } text_beat_type;

   typedef struct packed {
      logic [1:0]    mode;
      logic [7:0]    symbol;
      logic [31:0]   value;
      logic          known;
      text_beat_type beat;
   } stim_row_type;

   localparam text_beat_type NO_BEAT  = '0;
   localparam text_beat_type BAD_BEAT = '{8'h00, 1'b1, 1'b1};

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_mode;
   logic [7:0]  req_symbol;
   logic [31:0] req_value;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [7:0]  rsp_character;
   logic        rsp_last;
   logic        rsp_invalid_base;

   // Predicted alphabet and pending text
   logic [7:0]    alphabet_sym [ALPHABET_SIZE];
   int            alphabet_len;
   bit            sym_taken [256];
   bit            alphabet_broken;
   text_beat_type expected_text [$];

   int          failures;
   int          accepted_items;
   int          send_idle_pct;
   int          recv_stall_pct;
   bit          hold_request;
   int          hold_left;
   int          send_idle_by_phase [PHASES] = '{0, 66, 0, 15, 0};
   int          recv_stall_by_phase [PHASES] = '{0, 0, 66, 15, 0};

   // Directed rows: fixed text only where it is obvious
   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      '{MODE_CONVERT, 8'h00, 32'h0000_0000, 1'b1, BAD_BEAT},          // empty after reset
      '{MODE_APPEND,  8'h30, 32'h0000_0000, 1'b0, NO_BEAT},           // '0'
      '{MODE_CONVERT, 8'h00, 32'h0000_0005, 1'b1, BAD_BEAT},          // one symbol only
      '{MODE_APPEND,  8'h31, 32'hFFFF_FFFF, 1'b0, NO_BEAT},           // '1'
      '{MODE_CONVERT, 8'hFF, 32'h0000_0000, 1'b1, '{8'h30, 1'b1, 1'b0}},
      '{MODE_CONVERT, 8'h00, 32'h8000_0000, 1'b0, NO_BEAT},
      '{MODE_CONVERT, 8'h00, 32'h7FFF_FFFF, 1'b0, NO_BEAT},
      '{MODE_CONVERT, 8'h00, 32'hFFFF_FFFF, 1'b0, NO_BEAT},
      '{MODE_APPEND,  8'h00, 32'h0000_0000, 1'b0, NO_BEAT},           // byte zero
      '{MODE_CONVERT, 8'h00, 32'h8000_0000, 1'b0, NO_BEAT},
      '{MODE_APPEND,  8'hFF, 32'h0000_0000, 1'b0, NO_BEAT},
      '{MODE_CONVERT, 8'h00, 32'hFFFF_FFFB, 1'b0, NO_BEAT},
      '{MODE_UNUSED,  8'hAA, 32'h5555_5555, 1'b0, NO_BEAT},
      '{MODE_CONVERT, 8'h55, 32'h0000_0004, 1'b0, NO_BEAT},
      '{MODE_APPEND,  8'h30, 32'h0000_0000, 1'b0, NO_BEAT},           // repeat
      '{MODE_CONVERT, 8'h00, 32'h0000_0007, 1'b1, BAD_BEAT},
      '{MODE_CLEAR,   8'hFF, 32'hFFFF_FFFF, 1'b0, NO_BEAT},
      '{MODE_APPEND,  SYM_PLUS, 32'h0000_0000, 1'b0, NO_BEAT},
      '{MODE_APPEND,  8'h61, 32'h0000_0000, 1'b0, NO_BEAT},
      '{MODE_CONVERT, 8'h00, 32'h0000_0001, 1'b1, BAD_BEAT},
      '{MODE_CLEAR,   8'h00, 32'h0000_0000, 1'b0, NO_BEAT},
      '{MODE_APPEND,  8'h78, 32'h0000_0000, 1'b0, NO_BEAT},
      '{MODE_APPEND,  SYM_MINUS, 32'h0000_0000, 1'b0, NO_BEAT},
      '{MODE_CONVERT, 8'h00, 32'h8000_0000, 1'b1, BAD_BEAT},          // no stray sign
      '{MODE_CLEAR,   8'h00, 32'h0000_0000, 1'b0, NO_BEAT}
   };

   signed_integer_to_custom_radix_text_unit uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_symbol       (req_symbol),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_character    (rsp_character),
      .rsp_last         (rsp_last),
      .rsp_invalid_base (rsp_invalid_base)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Update the alphabet and queue the text that one beat should produce
   function automatic void predict_text(logic [1:0] mode, logic [7:0] symbol,
                                        logic [31:0] value);
      logic [31:0]   mag;
      int unsigned   base;
      logic [7:0]    digits [$];
      text_beat_type beat;
      case (mode)
         MODE_CLEAR: begin
            alphabet_len    = 0;
            alphabet_broken = 1'b0;
            foreach (sym_taken[i]) sym_taken[i] = 1'b0;
         end
         MODE_APPEND: begin
            if (alphabet_len >= ALPHABET_SIZE) begin
               alphabet_broken = 1'b1;
            end else begin
               if (symbol == SYM_PLUS || symbol == SYM_MINUS || sym_taken[symbol])
                  alphabet_broken = 1'b1;
               sym_taken[symbol]              = 1'b1;
               alphabet_sym[8'(alphabet_len)] = symbol;
               alphabet_len++;
            end
         end
         MODE_CONVERT: begin
            if (alphabet_len < 2 || alphabet_broken) begin
               expected_text.push_back(BAD_BEAT);
            end else begin
               base = alphabet_len;
               // two's complement negate leaves the minimum as its own magnitude
               mag  = value[31] ? -value : value;
               do begin
                  digits.push_front(alphabet_sym[8'(mag % base)]);
                  mag = mag / base;
               end while (mag != 0);
               if (value[31]) begin
                  beat = '{SYM_MINUS, 1'b0, 1'b0};
                  expected_text.push_back(beat);
               end
               foreach (digits[i]) begin
                  beat = '{digits[i], i == digits.size() - 1, 1'b0};
                  expected_text.push_back(beat);
               end
            end
         end
         default: ;
      endcase
   endfunction

   function automatic stim_row_type make_row(logic [1:0] mode, logic [7:0] symbol,
                                             logic [31:0] value);
      stim_row_type row;
      row = '{mode, symbol, value, 1'b0, NO_BEAT};
      return row;
   endfunction

   // Offer one beat after a random gap, hold it until taken, then predict
   task automatic send_beat(input stim_row_type row);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_mode   <= row.mode;
      req_symbol <= row.symbol;
      req_value  <= row.value;
      do @(posedge clock); while (!req_ready);
      if (row.mode != MODE_UNUSED) accepted_items++;
      if (row.known) expected_text.push_back(row.beat);
      else predict_text(row.mode, row.symbol, row.value);
   endtask

   // Build a fresh or extended alphabet, then convert a handful of values
   task automatic run_sequence();
      logic [7:0]  pool [$];
      logic [7:0]  swap;
      logic [31:0] value;
      int unsigned size;
      int unsigned pick;
      int unsigned j;
      int unsigned converts;
      for (int b = 0; b < 256; b++)
         if (b != SYM_PLUS && b != SYM_MINUS) pool.push_back(b[7:0]);
      pick = $urandom_range(99);
      if (pick < 8) size = $urandom_range(1);
      else if (pick < 78) size = $urandom_range(12, 2);
      else if (pick < 95) size = $urandom_range(64, 13);
      else size = $urandom_range(254, 65);
      // shuffle only the head that is used
      for (int unsigned i = 0; i < size; i++) begin
         j       = $urandom_range(pool.size() - 1, i);
         swap    = pool[i];
         pool[i] = pool[j];
         pool[j] = swap;
      end
      // break some alphabets with a sign symbol or a repeat
      if (size >= 2 && $urandom_range(99) < 12) begin
         j = $urandom_range(size - 1, 1);
         if ($urandom_range(1)) pool[j] = $urandom_range(1) ? SYM_PLUS : SYM_MINUS;
         else pool[j] = pool[$urandom_range(j - 1)];
      end
      if ($urandom_range(9) != 0) send_beat(make_row(MODE_CLEAR, 8'($urandom()), $urandom()));
      for (int unsigned i = 0; i < size; i++) begin
         if ($urandom_range(99) < 3)
            send_beat(make_row(MODE_UNUSED, 8'($urandom()), $urandom()));
         send_beat(make_row(MODE_APPEND, pool[i], $urandom()));
      end
      converts = $urandom_range(6, 1);
      repeat (converts) begin
         case ($urandom_range(9))
            0: begin
               pick  = $urandom_range(4);
               value = pick == 0 ? 32'h8000_0000 : pick == 1 ? 32'h7FFF_FFFF :
                       pick == 2 ? 32'h0000_0000 : pick == 3 ? 32'h0000_0001 :
                       32'hFFFF_FFFF;
            end
            1, 2, 3: value = $urandom();
            4, 5, 6: value = $urandom_range(1000);
            default: value = $urandom() >> $urandom_range(31);
         endcase
         if (value != 32'h8000_0000 && $urandom_range(2) == 0) value = -value;
         if ($urandom_range(99) < 5)
            send_beat(make_row(MODE_APPEND, 8'($urandom()), $urandom()));
         send_beat(make_row(MODE_CONVERT, 8'($urandom()), value));
      end
   endtask

   // Receiver: random stalls, plus one long hold counted here
   initial begin
      rsp_ready = 1'b0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // Compare every accepted result beat with the oldest expectation
   always @(posedge clock) begin : check_text
      text_beat_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_text.size() == 0) begin
            $error("result beat with nothing expected: character %02h", rsp_character);
            failures++;
         end else begin
            want = expected_text.pop_front();
            if (rsp_character !== want.character) begin
               $error("character: expected %02h, got %02h", want.character, rsp_character);
               failures++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %0b, got %0b", want.last, rsp_last);
               failures++;
            end
            if (rsp_invalid_base !== want.invalid_base) begin
               $error("invalid_base: expected %0b, got %0b", want.invalid_base,
                      rsp_invalid_base);
               failures++;
            end
         end
      end
   end

   // Watchdog: end the run after too long without any beat
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
         else quiet_cycles++;
      end
      $display("Mismatches found");
      $finish;
   end

   initial begin : stimulus
      int random_start;
      failures        = 0;
      accepted_items  = 0;
      send_idle_pct   = 0;
      recv_stall_pct  = 0;
      hold_request    = 1'b0;
      alphabet_len    = 0;
      alphabet_broken = 1'b0;
      foreach (sym_taken[i]) sym_taken[i] = 1'b0;
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_mode   = MODE_CLEAR;
      req_symbol = 8'h00;
      req_value  = 32'h0000_0000;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) send_beat(directed_rows[i]);

      // Widest alphabet, then sign symbols to fill it and one append past the end
      send_idle_pct  = 15;
      recv_stall_pct = 15;
      send_beat(make_row(MODE_CLEAR, 8'($urandom()), $urandom()));
      for (int b = 255; b >= 0; b--)
         if (b != SYM_PLUS && b != SYM_MINUS)
            send_beat(make_row(MODE_APPEND, b[7:0], $urandom()));
      send_beat(make_row(MODE_CONVERT, 8'($urandom()), 32'h8000_0000));
      send_beat(make_row(MODE_CONVERT, 8'($urandom()), 32'h7FFF_FFFF));
      send_beat(make_row(MODE_CONVERT, 8'($urandom()), $urandom()));
      send_beat(make_row(MODE_APPEND, SYM_PLUS, $urandom()));
      send_beat(make_row(MODE_APPEND, SYM_MINUS, $urandom()));
      send_beat(make_row(MODE_APPEND, 8'($urandom()), $urandom()));
      send_beat(make_row(MODE_CONVERT, 8'($urandom()), $urandom()));

      // Random sequences across the idling phases
      random_start = accepted_items;
      for (int p = 0; p < PHASES; p++) begin
         send_idle_pct  = send_idle_by_phase[p];
         recv_stall_pct = recv_stall_by_phase[p];
         if (p == PRESSURE_PHASE) hold_request = 1'b1;
         while (accepted_items - random_start < (p + 1) * RANDOM_ITEMS / PHASES)
            run_sequence();
      end
      req_valid <= 1'b0;

      // Drain the outstanding text, then allow a few more cycles
      while (expected_text.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

endmodule
